FILE: rtl/gtg_pkg.sv
// Shared types, constants and helper functions for the grid tile geometry core.
// Used by gtg_div and grid_tile_geometry_core; depends on nothing else.
package gtg_pkg;

    // Largest tile count that forms a grid; larger counts give a cleared result.
    localparam int MaxTiles = 64;
    // Largest row or column count that a grid of MaxTiles tiles can reach.
    localparam int GridMax = 8;

    // Configuration register indexes.
    localparam logic [1:0] RegAreaLeft   = 2'd0;
    localparam logic [1:0] RegAreaTop    = 2'd1;
    localparam logic [1:0] RegAreaWidth  = 2'd2;
    localparam logic [1:0] RegAreaHeight = 2'd3;

    // Grid shape for one tile count.
    typedef struct packed {
        logic [3:0] rows;
        logic [3:0] cols;
    } grid_t;

    // Per-item control that travels beside the divider stages.
    typedef struct packed {
        logic       idx_ok;
        logic [2:0] row;
        logic [2:0] col;
        logic       last_row;
        logic       last_col;
        logic [3:0] rows;
        logic [3:0] cols;
    } side_t;

    // Rows are the smallest r with r*r >= n, columns the smallest c with
    // c*rows >= n; a count of two lays out side by side.
    function automatic grid_t grid_shape(input logic [6:0] n);
        grid_t g;
        g.rows = '0;
        g.cols = '0;
        if (n == 7'd0 || int'(n) > MaxTiles) begin
            g.rows = '0;
            g.cols = '0;
        end
        else if (n == 7'd2) begin
            g.rows = 4'd1;
            g.cols = 4'd2;
        end
        else begin
            for (int r = GridMax; r >= 1; r--) begin
                if (r * r >= int'(n)) begin
                    g.rows = 4'(r);
                end
            end
            for (int c = GridMax; c >= 1; c--) begin
                if (c * int'(g.rows) >= int'(n)) begin
                    g.cols = 4'(c);
                end
            end
        end
        return g;
    endfunction

    // floor(2^16 / d) for the small divisors of the grid.
    function automatic logic [16:0] recip(input logic [3:0] d);
        logic [16:0] m;
        case (d)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21845;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13107;
            4'd6:    m = 17'd10922;
            4'd7:    m = 17'd9362;
            4'd8:    m = 17'd8192;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/gtg_div.sv
// Two-stage ceiling divider of a pixel span by a small count (1 to 8).
// Uses a reciprocal multiply and one correction step; depends on gtg_pkg.
module gtg_div (
    input  logic        clk,
    input  logic        en_a,
    input  logic        en_b,
    input  logic [14:0] num,
    input  logic [3:0]  den,
    output logic [14:0] quo
);

    logic [15:0] a_reg;
    logic [15:0] a_next;
    logic [3:0]  d_reg;
    logic [32:0] prod_reg;
    logic [32:0] prod_next;
    logic [14:0] q_reg;
    logic [14:0] q_next;
    logic [16:0] q_est;
    logic [20:0] qd;
    logic [20:0] rem;

    // First stage: bias the span for a ceiling and multiply by the reciprocal.
    always_comb
    begin
        a_next    = 16'({1'b0, num}) + 16'(den) - 16'd1;
        prod_next = 33'(a_next) * 33'(gtg_pkg::recip(den));
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_reg    <= a_next;
            d_reg    <= den;
            prod_reg <= prod_next;
        end
    end

    // Second stage: the estimate is exact or one low; the remainder fixes it.
    always_comb
    begin
        q_est  = prod_reg[32:16];
        qd     = 21'(q_est) * 21'(d_reg);
        rem    = 21'(a_reg) - qd;
        q_next = (rem >= 21'(d_reg)) ? 15'(q_est + 17'd1) : 15'(q_est);
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            q_reg <= q_next;
        end
    end

    assign quo = q_reg;

endmodule

FILE: rtl/grid_tile_geometry_core.sv
// Grid tile geometry core: pixel rectangle of one tile in a column-major grid.
// An accepted item passes stage registers 1 to 6 in order; m_tvalid is the stage 6 valid bit.
// One item per cycle unless m_tready stalls; six-stage pipeline with a two-stage divider.
// Reset clears all stage valid bits and loads the default 1920x1080 area at 0,0.
// Depends on gtg_pkg and gtg_div.
module grid_tile_geometry_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] tile_count, [12:7] tile_index, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [16:0] tile_left, [33:17] tile_top,
                                   // [48:34] tile_width, [63:49] tile_height,
                                   // [67:64] grid_rows, [71:68] grid_cols
    output logic [0:0]  m_tuser,   // [0] index_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic signed [15:0] area_left_reg;
    logic signed [15:0] area_top_reg;
    logic [14:0]        area_width_reg;
    logic [14:0]        area_height_reg;

    // Stage valid bits and advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // Stage 1: captured input.
    logic [6:0] n1_reg;
    logic [5:0] k1_reg;

    // Stage 2: grid shape.
    gtg_pkg::grid_t grid2_next;
    gtg_pkg::grid_t grid2_reg;
    logic [6:0]     n2_reg;
    logic [5:0]     k2_reg;
    logic           ok2_reg;
    logic           ok2_next;

    // Stage 3: tile position within the grid.
    gtg_pkg::side_t side3_next;
    gtg_pkg::side_t side3_reg;
    logic [3:0]     lrows3_next;
    logic [3:0]     lrows3_reg;
    logic [6:0]     full3;

    // Stages 4 and 5: sideband beside the dividers.
    gtg_pkg::side_t side4_reg;
    gtg_pkg::side_t side5_reg;
    logic [14:0]    step_x;
    logic [14:0]    step_y;

    // Stage 6: output register.
    logic signed [16:0] left6_next, left6_reg;
    logic signed [16:0] top6_next, top6_reg;
    logic [14:0]        width6_next, width6_reg;
    logic [14:0]        height6_next, height6_reg;
    logic [3:0]         rows6_reg;
    logic [3:0]         cols6_reg;
    logic               ok6_reg;

    logic [17:0]        prod_x;
    logic [17:0]        prod_y;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] rest_x;
    logic signed [19:0] rest_y;
    logic signed [19:0] size_x;
    logic signed [19:0] size_y;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_left_reg   <= 16'sd0;
            area_top_reg    <= 16'sd0;
            area_width_reg  <= 15'd1920;
            area_height_reg <= 15'd1080;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gtg_pkg::RegAreaLeft:   area_left_reg   <= $signed(cfg_data);
                gtg_pkg::RegAreaTop:    area_top_reg    <= $signed(cfg_data);
                gtg_pkg::RegAreaWidth:  area_width_reg  <= cfg_data[14:0];
                gtg_pkg::RegAreaHeight: area_height_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Each stage advances when it is empty or the next one advances.
    assign en6      = !v6_reg || m_tready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: capture the item.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            n1_reg <= s_tdata[6:0];
            k1_reg <= s_tdata[12:7];
        end
    end

    // Stage 2: grid shape from the count and the index check.
    always_comb
    begin
        grid2_next = gtg_pkg::grid_shape(n1_reg);
        ok2_next   = (grid2_next.rows != 4'd0) && (7'(k1_reg) < n1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            grid2_reg <= grid2_next;
            n2_reg    <= n1_reg;
            k2_reg    <= k1_reg;
            ok2_reg   <= ok2_next;
        end
    end

    // Stage 3: column and row of the tile, and rows in its column.
    always_comb
    begin
        side3_next.col = 3'd0;
        for (int c = 1; c < gtg_pkg::GridMax; c++)
        begin
            if (c * int'(grid2_reg.rows) <= int'(k2_reg))
            begin
                side3_next.col = 3'(c);
            end
        end
        side3_next.row = 3'(7'(k2_reg) - 7'(side3_next.col) * 7'(grid2_reg.rows));
        full3 = 7'(grid2_reg.rows) * 7'(grid2_reg.cols) - 7'(grid2_reg.rows);
        lrows3_next = (7'(k2_reg) >= full3) ? 4'(n2_reg - full3) : grid2_reg.rows;
        side3_next.idx_ok   = ok2_reg;
        side3_next.last_row = (4'(side3_next.row) == lrows3_next - 4'd1);
        side3_next.last_col = (4'(side3_next.col) == grid2_reg.cols - 4'd1);
        side3_next.rows     = grid2_reg.rows;
        side3_next.cols     = grid2_reg.cols;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            side3_reg  <= side3_next;
            lrows3_reg <= lrows3_next;
        end
    end

    // Stages 4 and 5: tile step along each axis.
    gtg_div u_div_x (
        .clk  (clk),
        .en_a (en4),
        .en_b (en5),
        .num  (area_width_reg),
        .den  (side3_reg.cols),
        .quo  (step_x)
    );

    gtg_div u_div_y (
        .clk  (clk),
        .en_a (en4),
        .en_b (en5),
        .num  (area_height_reg),
        .den  (lrows3_reg),
        .quo  (step_y)
    );

    always_ff @(posedge clk)
    begin
        if (en4) side4_reg <= side3_reg;
        if (en5) side5_reg <= side4_reg;
    end

    // Stage 6: edges and sizes, clamped; the last row and column take the rest.
    always_comb
    begin
        prod_x = 18'(step_x) * 18'(side5_reg.col);
        prod_y = 18'(step_y) * 18'(side5_reg.row);
        pos_x  = 20'(area_left_reg) + $signed({2'b00, prod_x});
        pos_y  = 20'(area_top_reg) + $signed({2'b00, prod_y});
        rest_x = $signed({5'd0, area_width_reg}) - $signed({2'b00, prod_x});
        rest_y = $signed({5'd0, area_height_reg}) - $signed({2'b00, prod_y});
        size_x = side5_reg.last_col ? rest_x : $signed({5'd0, step_x});
        size_y = side5_reg.last_row ? rest_y : $signed({5'd0, step_y});

        if (pos_x < -20'sd32768)     left6_next = -17'sd32768;
        else if (pos_x > 20'sd49151) left6_next = 17'sd49151;
        else                         left6_next = pos_x[16:0];

        if (pos_y < -20'sd32768)     top6_next = -17'sd32768;
        else if (pos_y > 20'sd49151) top6_next = 17'sd49151;
        else                         top6_next = pos_y[16:0];

        if (size_x < 20'sd0)         width6_next = 15'd0;
        else if (size_x > 20'sd16384) width6_next = 15'd16384;
        else                         width6_next = size_x[14:0];

        if (size_y < 20'sd0)         height6_next = 15'd0;
        else if (size_y > 20'sd16384) height6_next = 15'd16384;
        else                         height6_next = size_y[14:0];

        // An index outside the grid gives cleared geometry.
        if (!side5_reg.idx_ok)
        begin
            left6_next   = '0;
            top6_next    = '0;
            width6_next  = '0;
            height6_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            left6_reg   <= left6_next;
            top6_reg    <= top6_next;
            width6_reg  <= width6_next;
            height6_reg <= height6_next;
            rows6_reg   <= side5_reg.rows;
            cols6_reg   <= side5_reg.cols;
            ok6_reg     <= side5_reg.idx_ok;
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = {cols6_reg, rows6_reg, height6_reg, width6_reg,
                       top6_reg, left6_reg};
    assign m_tuser  = ok6_reg;

endmodule

FILE: tb/sv/tile_geometry_checker.sv
// Checker for grid_tile_geometry_core: watches the query, result and register channels,
// predicts each tile rectangle and compares it with the block's result, field by field.
// Depends on gtg_pkg for the tile limit and the register indexes.
module tile_geometry_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          rects_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // One tile rectangle as the block reports it.
    typedef struct packed {
        logic [16:0] left;
        logic [16:0] top;
        logic [14:0] width;
        logic [14:0] height;
        logic [3:0]  rows;
        logic [3:0]  cols;
        logic        valid;
    } tile_rect_t;

    // Local copy of the work area registers.
    int wa_left;
    int wa_top;
    int wa_width;
    int wa_height;

    tile_rect_t rect_q[$];

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rectangle of tile k in the grid for n tiles over the current work area.
    function automatic tile_rect_t tile_rect(input int n, input int k);
        tile_rect_t r;
        int rows;
        int cols;
        int row;
        int col;
        int full;
        int lrows;
        int step;
        int x;
        int y;
        int w;
        int h;
        r = '0;
        if (n == 0 || n > gtg_pkg::MaxTiles)
        begin
            return r;
        end
        if (n == 2)
        begin
            rows = 1;
            cols = 2;
        end
        else
        begin
            rows = 1;
            while (rows * rows < n)
                rows++;
            cols = (n + rows - 1) / rows;
        end
        r.rows = 4'(rows);
        r.cols = 4'(cols);
        if (k >= n)
        begin
            return r;
        end
        row = k % rows;
        col = k / rows;
        // The last column spreads its leftover tiles over the full height.
        full = rows * cols - rows;
        lrows = (k >= full) ? n - full : rows;

        step = (wa_height + lrows - 1) / lrows;
        y = wa_top + step * row;
        h = (row == lrows - 1) ? wa_height - step * row : step;

        step = (wa_width + cols - 1) / cols;
        x = wa_left + step * col;
        w = (col == cols - 1) ? wa_width - step * col : step;

        r.left   = 17'(clamp(x, -32768, 49151));
        r.top    = 17'(clamp(y, -32768, 49151));
        r.width  = 15'(clamp(w, 0, 16384));
        r.height = 15'(clamp(h, 0, 16384));
        r.valid  = 1'b1;
        return r;
    endfunction

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic report_mismatch(input string msg);
        if (errors < 200)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_rect(input tile_rect_t got, input tile_rect_t want);
        if (got.left != want.left)
            report_mismatch($sformatf("tile_left got %0d expected %0d",
                                      $signed(got.left), $signed(want.left)));
        if (got.top != want.top)
            report_mismatch($sformatf("tile_top got %0d expected %0d",
                                      $signed(got.top), $signed(want.top)));
        if (got.width != want.width)
            report_mismatch($sformatf("tile_width got %0d expected %0d",
                                      got.width, want.width));
        if (got.height != want.height)
            report_mismatch($sformatf("tile_height got %0d expected %0d",
                                      got.height, want.height));
        if (got.rows != want.rows)
            report_mismatch($sformatf("grid_rows got %0d expected %0d", got.rows, want.rows));
        if (got.cols != want.cols)
            report_mismatch($sformatf("grid_cols got %0d expected %0d", got.cols, want.cols));
        if (got.valid != want.valid)
            report_mismatch($sformatf("index_valid got %0d expected %0d",
                                      got.valid, want.valid));
    endtask

    // Sample all three channels at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        tile_rect_t got;
        if (!rst_n)
        begin
            wa_left = 0;
            wa_top = 0;
            wa_width = 1920;
            wa_height = 1080;
            rect_q.delete();
            errors = 0;
            rects_checked = 0;
            pending <= 0;
        end
        else
        begin
            // Results come back in query order.
            if (m_tvalid && m_tready)
            begin
                got.left   = m_tdata[16:0];
                got.top    = m_tdata[33:17];
                got.width  = m_tdata[48:34];
                got.height = m_tdata[63:49];
                got.rows   = m_tdata[67:64];
                got.cols   = m_tdata[71:68];
                got.valid  = m_tuser[0];
                if (rect_q.size() == 0)
                    report_mismatch("result with no query outstanding");
                else
                    compare_rect(got, rect_q.pop_front());
                rects_checked++;
            end

            // Every query yields exactly one result.
            if (s_tvalid && s_tready)
                rect_q = {rect_q, tile_rect(int'(s_tdata[6:0]), int'(s_tdata[12:7]))};

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gtg_pkg::RegAreaLeft:   wa_left = int'($signed(cfg_data));
                    gtg_pkg::RegAreaTop:    wa_top = int'($signed(cfg_data));
                    gtg_pkg::RegAreaWidth:  wa_width = int'(cfg_data[14:0]);
                    gtg_pkg::RegAreaHeight: wa_height = int'(cfg_data[14:0]);
                    default: ;
                endcase
            end

            pending <= rect_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_grid_tile_geometry_core.sv
// Top of the grid_tile_geometry_core testbench: clock, reset, query and register stimulus.
// Instantiates the block and tile_geometry_checker; depends on gtg_pkg.
module tb_grid_tile_geometry_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int RandomPerPhase = 180;
    localparam int NumPhases = 9;
    localparam int HoldCycles = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = gtg_pkg::RegAreaLeft;
    logic [15:0] cfg_data = '0;

    int errors;
    int pending;
    int rects_checked;
    int cycle_count = 0;
    int queries_sent = 0;

    // Stimulus controls: calm turns idling off on both sides, a toggle of
    // hold_req makes the receiver hold off for a long stretch.
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    always #6 clk = ~clk;

    grid_tile_geometry_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tile_geometry_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .rects_checked (rects_checked)
    );

    // Run guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("tb_grid_tile_geometry_core NOT OK");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // Offer one query and wait for it to be taken, then maybe idle a little.
    task automatic send_query(input logic [6:0] count, input logic [5:0] index);
        s_tdata <= {3'b000, index, count};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        queries_sent++;
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_area(input logic [15:0] left, input logic [15:0] top,
                              input logic [15:0] width, input logic [15:0] height);
        write_reg(gtg_pkg::RegAreaLeft, left);
        write_reg(gtg_pkg::RegAreaTop, top);
        write_reg(gtg_pkg::RegAreaWidth, width);
        write_reg(gtg_pkg::RegAreaHeight, height);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed queries, some indexes past the count, some wild counts.
    task automatic send_random_query();
        int pick;
        int count;
        int index;
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            count = $urandom_range(1, gtg_pkg::MaxTiles);
            index = $urandom_range(0, count - 1);
        end
        else if (pick < 90)
        begin
            count = $urandom_range(1, gtg_pkg::MaxTiles);
            index = $urandom_range(0, 63);
        end
        else
        begin
            count = $urandom_range(0, 127);
            index = $urandom_range(0, 63);
        end
        send_query(7'(count), 6'(index));
    endtask

    function automatic logic [15:0] random_size();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(1, 16384));
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries on the default 1920x1080 area.
        send_query(7'd0, 6'd0);      // zero count
        send_query(7'd0, 6'd63);
        send_query(7'd1, 6'd0);      // single tile fills the area
        send_query(7'd1, 6'd1);      // index past the count
        send_query(7'd2, 6'd0);      // two tiles side by side
        send_query(7'd2, 6'd1);
        send_query(7'd2, 6'd2);
        send_query(7'd3, 6'd0);
        send_query(7'd3, 6'd2);
        send_query(7'd5, 6'd3);      // leftover tiles in the last column
        send_query(7'd5, 6'd4);
        send_query(7'd7, 6'd6);      // last column holds one tile
        send_query(7'd8, 6'd7);
        send_query(7'd10, 6'd9);
        send_query(7'd63, 6'd62);
        send_query(7'd64, 6'd0);     // largest grid
        send_query(7'd64, 6'd56);
        send_query(7'd64, 6'd63);
        send_query(7'd65, 6'd0);     // count above the tile limit
        send_query(7'd100, 6'd5);
        send_query(7'd127, 6'd63);

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                case (phase)
                    // Most negative origin and a one-pixel area: sizes go negative.
                    1: write_area(16'h8000, 16'h8000, 16'd1, 16'd1);
                    // Most positive origin and oversized area: edges and sizes saturate.
                    2: write_area(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
                    // Zero area: tiles stack at the edge with no size.
                    3: write_area(16'd0, 16'd0, 16'd0, 16'd0);
                    4: write_area(16'd0, 16'd0, 16'd16384, 16'd16384);
                    default: write_area(16'($urandom), 16'($urandom),
                                        random_size(), random_size());
                endcase
            end
            calm = (phase == 4);
            // Long receiver hold-off while queries keep coming.
            if (phase == 2)
                hold_req = ~hold_req;
            for (int i = 0; i < RandomPerPhase; i++)
            begin
                // Pause the sender until all results are back, once.
                if (phase == 6 && i == RandomPerPhase / 2)
                    drain_results();
                send_random_query();
            end
        end

        drain_results();
        calm = 1'b0;
        $display("Sent %0d tile queries, checked %0d results over %0d work-area settings,",
                 queries_sent, rects_checked, NumPhases);
        $display("including extreme origins, zero, tiny and oversized areas, and bad counts.");
        if (errors == 0)
            $display("tb_grid_tile_geometry_core OK");
        else
            $display("tb_grid_tile_geometry_core NOT OK");
        $finish;
    end

endmodule
